/* hdl/bsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types, sizes and coefficient tables
// Fixed-point formats, band-pass filter coefficients in Q.40 and the
// control structs passed between the sequencer, MAC and tap cells.
// ----------------------------------------------------------------------------
package bsp_pkg;

   localparam int ORDER       = 9;
   localparam int TAP_W       = 4;
   localparam int SAMPLE_BITS = 16;
   localparam int HIST_W      = 48;
   localparam int FF_W        = 26;
   localparam int PART_W      = 24;
   localparam int MOPA_W      = 26;
   localparam int MOPB_W      = 25;
   localparam int PROD_W      = MOPA_W + MOPB_W;
   localparam int PACC_W      = 97;
   localparam int TOTAL_W     = 64;
   localparam int FFSUM_W     = 48;
   localparam int FRAC        = 40;
   localparam int OUT_SHIFT   = 25;
   localparam int THR_SHIFT   = 25;
   localparam int FILT_W      = 18;
   localparam int THR_W       = 15;
   localparam int PHASE_W     = 32;
   localparam int ANGLE_W     = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int LAST_PART   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 8'd1;
   localparam logic [THR_W-1:0]     THRESHOLD_RESET = 15'd1638;

   localparam logic [63:0] TWO40 = 64'd1099511627776;
   localparam logic [63:0] D6  = 64'd1000000;
   localparam logic [63:0] D5  = 64'd100000;
   localparam logic [63:0] D7  = 64'd10000000;
   localparam logic [63:0] D11 = 64'd100000000000;
   localparam logic [63:0] D12 = 64'd1000000000000;
   localparam logic [63:0] D13 = 64'd10000000000000;

   // coefficient magnitudes, rounded to nearest in Q.40
   localparam logic [63:0] QB0 = (64'd9684457 * TWO40 + D13 / 2) / D13;
   localparam logic [63:0] QB1 = (64'd6779120 * TWO40 + D12 / 2) / D12;
   localparam logic [63:0] QB2 = (64'd1936891 * TWO40 + D11 / 2) / D11;
   localparam logic [63:0] QB3 = (64'd2711648 * TWO40 + D11 / 2) / D11;
   localparam logic [63:0] QB4 = (64'd1355824 * TWO40 + D11 / 2) / D11;
   localparam logic [63:0] QA1 = (64'd7616874 * TWO40 + D6 / 2) / D6;
   localparam logic [63:0] QA2 = (64'd2634041 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA3 = (64'd5424242 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA4 = (64'd7325881 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA5 = (64'd6726091 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA6 = (64'd4196424 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA7 = (64'd1715111 * TWO40 + D5 / 2) / D5;
   localparam logic [63:0] QA8 = (64'd4166027 * TWO40 + D6 / 2) / D6;
   localparam logic [63:0] QA9 = (64'd4581673 * TWO40 + D7 / 2) / D7;

   typedef enum logic [2:0] {
      MAC_NONE,
      MAC_FF_FIRST,
      MAC_FF,
      MAC_FB_START,
      MAC_FB_FIRST,
      MAC_FB_MID,
      MAC_FB_LAST,
      MAC_FOLD
   } mac_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FF,
      S_FB,
      S_FOLD,
      S_WAIT,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      mac_op_type               op;
      logic signed [MOPA_W-1:0] a;
      logic signed [MOPB_W-1:0] b;
   } mac_req_type;

   typedef struct packed {
      logic rotate;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [HIST_W-1:0]      y;
   } cell_data_type;

   function automatic logic signed [FF_W-1:0] ff_coef(input logic [TAP_W-1:0] idx);
      logic signed [FF_W-1:0] c;
      case (idx)
         4'd0:    c = FF_W'(QB0);
         4'd1:    c = FF_W'(QB1);
         4'd2:    c = FF_W'(QB2);
         4'd3:    c = FF_W'(QB3);
         4'd4:    c = FF_W'(QB4);
         4'd5:    c = FF_W'(-QB4);
         4'd6:    c = FF_W'(-QB3);
         4'd7:    c = FF_W'(-QB2);
         4'd8:    c = FF_W'(-QB1);
         4'd9:    c = FF_W'(-QB0);
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [HIST_W-1:0] fb_coef(input logic [TAP_W-1:0] idx);
      logic signed [HIST_W-1:0] c;
      case (idx)
         4'd1:    c = HIST_W'(-QA1);
         4'd2:    c = HIST_W'(QA2);
         4'd3:    c = HIST_W'(-QA3);
         4'd4:    c = HIST_W'(QA4);
         4'd5:    c = HIST_W'(-QA5);
         4'd6:    c = HIST_W'(QA6);
         4'd7:    c = HIST_W'(-QA7);
         4'd8:    c = HIST_W'(QA8);
         4'd9:    c = HIST_W'(-QA9);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/bsp_tap_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_tap_cell: one history tap
// Holds one input sample and one output value; rotates toward the head of
// the chain during a filter pass and shifts away from it on commit.
// ----------------------------------------------------------------------------
module bsp_tap_cell
   import bsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctl_type  ctl,
   input  wire cell_data_type up_in,
   input  wire cell_data_type down_in,
   output cell_data_type      q
);

   cell_data_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = down_in;
      end else if (ctl.rotate) begin
         data_in = up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule
`default_nettype wire

/* hdl/bsp_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_mac: shared multiply-accumulate
// One registered 26x25 multiplier; feed-forward sum, exact wide feedback
// product built from four partials, and the running filter total.
// ----------------------------------------------------------------------------
module bsp_mac
   import bsp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mac_req_type        req,
   output logic signed [TOTAL_W-1:0] total
);

   mac_op_type                op_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [FFSUM_W-1:0] ffsum_ff, ffsum_in;
   logic signed [PACC_W-1:0]  pacc_ff, pacc_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [PACC_W-1:0]  prod_ext;
   logic signed [PACC_W-1:0]  pacc_shr;
   logic signed [TOTAL_W-1:0] fold;
   logic signed [FFSUM_W-1:0] ff_shr;
   logic signed [TOTAL_W-1:0] ff_ext;

   assign prod_in  = req.a * req.b;
   assign prod_ext = {{(PACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign pacc_shr = pacc_ff >>> FRAC;
   assign fold     = TOTAL_W'(pacc_shr);
   assign ff_shr   = ffsum_ff >>> (SAMPLE_BITS - 1);
   assign ff_ext   = {{(TOTAL_W-FFSUM_W){ff_shr[FFSUM_W-1]}}, ff_shr};

   always_comb begin
      ffsum_in = ffsum_ff;
      pacc_in  = pacc_ff;
      total_in = total_ff;
      case (op_ff)
         MAC_FF_FIRST: ffsum_in = FFSUM_W'(prod_ext);
         MAC_FF:       ffsum_in = ffsum_ff + FFSUM_W'(prod_ext);
         MAC_FB_START: begin
            pacc_in  = prod_ext;
            total_in = ff_ext;
         end
         MAC_FB_FIRST: begin
            // fold the finished tap while the next one starts
            pacc_in  = prod_ext;
            total_in = total_ff - fold;
         end
         MAC_FB_MID:   pacc_in = pacc_ff + (prod_ext <<< PART_W);
         MAC_FB_LAST:  pacc_in = pacc_ff + (prod_ext <<< (2 * PART_W));
         MAC_FOLD:     total_in = total_ff - fold;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_NONE;
      end else begin
         op_ff <= req.op;
      end
      prod_ff  <= prod_in;
      ffsum_ff <= ffsum_in;
      pacc_ff  <= pacc_in;
      total_ff <= total_in;
   end

   assign total = total_ff;

endmodule
`default_nettype wire

/* hdl/bandpass_strobe_phase_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bandpass_strobe_phase_detector: band-pass filter, trigger and wheel angle
// Filters each sample, runs a hysteresis trigger and reports the wheel
// phase when the trigger fires.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample word. rsp_* returns one result word per sample:
//   filtered value, wheel angle and the fired / armed flags.
//   csr_* writes threshold (index 0) or phase_step (index 1); other indexes
//   are dropped. csr_ready is always high; write only while idle.
//   Each sample runs from acceptance to a result in the output register
//   through 10 feed-forward taps and 9 feedback taps of 4 partial products
//   each, all on one shared multiplier, then fold, a wait state for the
//   total to settle, and commit.
//   One sample is in work at a time and the idle state after commit takes
//   the next one; no sample is taken before the last commits. History lives in
//   a row of 9 tap cells that rotate past the multiplier and shift on commit.
//   A stalled rsp side holds the result; the next sample is still taken
//   and runs up to commit, where it waits for the output register.
//   Synchronous reset clears history, trigger, wheel phase and loads
//   threshold 1638 and phase_step 0.
// ----------------------------------------------------------------------------
module bandpass_strobe_phase_detector
   import bsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [15:0] sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,   // [17:0] filtered, [33:18] angle
   output logic [1:0]                 rsp_tuser,   // [0] fired, [1] armed
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic signed [TOTAL_W-1:0] HIST_MAX =
      TOTAL_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
   localparam logic signed [TOTAL_W-1:0] HIST_MIN = -HIST_MAX - TOTAL_W'(1);
   localparam logic signed [HIST_W-1:0] FILT_MAX = HIST_W'((1 <<< (FILT_W - 1)) - 1);
   localparam logic signed [HIST_W-1:0] FILT_MIN = -FILT_MAX - HIST_W'(1);

   seq_state_type state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [1:0] part_ff, part_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [THR_W-1:0] threshold_ff;
   logic [PHASE_W-1:0] step_ff;
   logic [PHASE_W-1:0] wheel_ff, wheel_in;
   logic lit_ff, lit_in;
   logic rsp_valid_ff;
   logic signed [FILT_W-1:0] filt_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic fired_ff, armed_ff;

   mac_req_type mac_req;
   cell_ctl_type cell_ctl;
   cell_data_type new_data;
   cell_data_type cell_q [ORDER];
   logic signed [TOTAL_W-1:0] total;
   logic req_accept, commit;
   logic signed [HIST_W-1:0] y_sat, filt_wide, thr_ext, a_full;
   logic signed [FILT_W-1:0] filt_sat;
   logic fire, arm;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      part_in  = part_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_FF;
               tap_in   = '0;
            end
         end
         S_FF: begin
            if (tap_ff == TAP_W'(ORDER)) begin
               state_in = S_FB;
               tap_in   = TAP_W'(1);
               part_in  = '0;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         S_FB: begin
            part_in = part_ff + 2'd1;
            if (part_ff == 2'(LAST_PART)) begin
               if (tap_ff == TAP_W'(ORDER)) begin
                  state_in = S_FOLD;
               end else begin
                  tap_in = tap_ff + TAP_W'(1);
               end
            end
         end
         S_FOLD: state_in = S_WAIT;
         S_WAIT: state_in = S_DONE;
         S_DONE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mac_req     = '{op: MAC_NONE, a: '0, b: '0};
      cell_ctl    = '0;
      req_tready  = 1'b0;
      commit      = 1'b0;
      a_full      = fb_coef(tap_ff);
      unique case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_FF: begin
            mac_req.op = (tap_ff == '0) ? MAC_FF_FIRST : MAC_FF;
            mac_req.a  = ff_coef(tap_ff);
            mac_req.b  = (tap_ff == '0) ? MOPB_W'(sample_ff) : MOPB_W'(cell_q[0].x);
            cell_ctl.rotate = (tap_ff != '0);
         end
         S_FB: begin
            if (part_ff == '0) begin
               mac_req.op = (tap_ff == TAP_W'(1)) ? MAC_FB_START : MAC_FB_FIRST;
            end else if (part_ff == 2'(LAST_PART)) begin
               mac_req.op = MAC_FB_LAST;
            end else begin
               mac_req.op = MAC_FB_MID;
            end
            // high halves signed, low halves zero-extended
            mac_req.a = part_ff[1] ? MOPA_W'($signed(a_full[HIST_W-1:PART_W]))
                                   : MOPA_W'({1'b0, a_full[PART_W-1:0]});
            mac_req.b = part_ff[0] ? MOPB_W'($signed(cell_q[0].y[HIST_W-1:PART_W]))
                                   : $signed({1'b0, cell_q[0].y[PART_W-1:0]});
            cell_ctl.rotate = (part_ff == 2'(LAST_PART));
         end
         S_FOLD: mac_req.op = MAC_FOLD;
         S_WAIT: begin
         end
         S_DONE: begin
            commit         = !rsp_valid_ff || rsp_tready;
            cell_ctl.shift = commit;
         end
         default: begin
         end
      endcase
   end

   // saturate, scale and run the trigger
   always_comb begin
      if (total > HIST_MAX) begin
         y_sat = HIST_MAX[HIST_W-1:0];
      end else if (total < HIST_MIN) begin
         y_sat = HIST_MIN[HIST_W-1:0];
      end else begin
         y_sat = total[HIST_W-1:0];
      end
      filt_wide = y_sat >>> OUT_SHIFT;
      if (filt_wide > FILT_MAX) begin
         filt_sat = FILT_MAX[FILT_W-1:0];
      end else if (filt_wide < FILT_MIN) begin
         filt_sat = FILT_MIN[FILT_W-1:0];
      end else begin
         filt_sat = filt_wide[FILT_W-1:0];
      end
      thr_ext = $signed({{(HIST_W-THR_W-THR_SHIFT){1'b0}}, threshold_ff,
                         {THR_SHIFT{1'b0}}});
      fire = !lit_ff && (y_sat > thr_ext);
      arm  = lit_ff && (y_sat < -thr_ext);
      lit_in = fire ? 1'b1 : (arm ? 1'b0 : lit_ff);
      wheel_in = wheel_ff + step_ff;
   end

   assign new_data = '{x: sample_ff, y: y_sat};

   genvar gi;
   generate
      for (gi = 0; gi < ORDER; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            bsp_tap_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .ctl     (cell_ctl),
               .up_in   (cell_q[(gi + 1) % ORDER]),
               .down_in (new_data),
               .q       (cell_q[gi])
            );
         end else begin : g_body
            bsp_tap_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .ctl     (cell_ctl),
               .up_in   (cell_q[(gi + 1) % ORDER]),
               .down_in (cell_q[gi - 1]),
               .q       (cell_q[gi])
            );
         end
      end
   endgenerate

   bsp_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .total (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ff       <= '0;
         part_ff      <= '0;
         threshold_ff <= THRESHOLD_RESET;
         step_ff      <= '0;
         wheel_ff     <= '0;
         lit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         part_ff  <= part_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_THRESHOLD:  threshold_ff <= csr_data[THR_W-1:0];
               CSR_PHASE_STEP: step_ff      <= csr_data[PHASE_W-1:0];
               default: begin
               end
            endcase
         end
         if (commit) begin
            wheel_ff     <= wheel_in;
            lit_ff       <= lit_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (commit) begin
         filt_ff  <= filt_sat;
         fired_ff <= fire;
         armed_ff <= lit_in;
         angle_ff <= fire ? wheel_ff[PHASE_W-1:PHASE_W-ANGLE_W] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, angle_ff, filt_ff};
   assign rsp_tuser  = {armed_ff, fired_ff};

`ifndef ASSERT_OFF
   a_fired_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("fired result without armed flag");

   a_angle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[33:18] == '0))
      else $error("angle nonzero on a result that did not fire");

   a_wheel_step: assert property (@(posedge clock) disable iff (reset)
      commit |=> (wheel_ff == $past(wheel_in)))
      else $error("wheel phase did not advance on commit");

   a_no_double_commit: assert property (@(posedge clock) disable iff (reset)
      commit |=> !commit)
      else $error("two commits in a row");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FB) |-> (tap_ff != '0) && (tap_ff <= TAP_W'(ORDER)))
      else $error("feedback tap out of range");
`endif

endmodule
`default_nettype wire
